@@ hdl/rlbr_pkg.sv @@
// Shared types, constants and helper functions of the ring log block reclaimer.
`default_nettype none
package rlbr_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int COUNT_BITS = 16;

  localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W     = COUNT_BITS;
  localparam int BOUND_W   = 48;
  localparam int TOT_W     = 11;
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = BOUND_W / MOD_BITS;
  localparam int STEP_W    = $clog2(MOD_STEPS + 1);

  localparam logic [TOT_W-1:0] RESET_RING = TOT_W'(1024);

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_APPEND  = 2'd1,
    OP_LOCK    = 2'd2,
    OP_UNLOCK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_NO_RSV  = 2'd2,
    ST_LIMIT   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_WALK,
    S_RSETUP,
    S_RECL,
    S_FIX,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [TOT_W-1:0] eff_blocks(input logic [TOT_W-1:0] ring);
    logic [TOT_W-1:0] n;
    n = ring;
    if (ring == '0) begin
      n = TOT_W'(1);
    end else if (32'(ring) > 32'(MAX_BLOCKS)) begin
      n = TOT_W'(MAX_BLOCKS);
    end
    return n;
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx,
                                               input logic [TOT_W-1:0] n);
    logic [IDX_W-1:0] r;
    r = idx + IDX_W'(1);
    if (32'(idx) + 32'd1 == 32'(n)) begin
      r = '0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/rlbr_count_mem.sv @@
// Reader counter memory: one write port, one read port, registered read data.
`default_nettype none
module rlbr_count_mem (
  input  wire logic                       clk,
  input  wire rlbr_pkg::mem_req_t         req,
  output logic [rlbr_pkg::CNT_W-1:0]      rdata
);

  logic [rlbr_pkg::CNT_W-1:0] mem [rlbr_pkg::MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

@@ hdl/rlbr_mod_unit.sv @@
// Remainder unit: 48-bit bound modulo block count, four quotient bits per cycle.
`default_nettype none
module rlbr_mod_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [rlbr_pkg::BOUND_W-1:0]   dividend,
  input  wire logic [rlbr_pkg::TOT_W-1:0]     divisor,
  output logic                                done,
  output logic [rlbr_pkg::IDX_W-1:0]          rem
);

  logic                          busy_r;
  logic                          done_r;
  logic [rlbr_pkg::STEP_W-1:0]   step_r;
  logic [rlbr_pkg::BOUND_W-1:0]  sh_r;
  logic [rlbr_pkg::TOT_W-1:0]    rem_r;
  logic [rlbr_pkg::TOT_W-1:0]    rem_nxt;

  always_comb begin
    logic [rlbr_pkg::TOT_W:0] t;
    rem_nxt = rem_r;
    for (int k = 0; k < rlbr_pkg::MOD_BITS; k++) begin
      t = {rem_nxt, sh_r[rlbr_pkg::BOUND_W-1-k]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      rem_nxt = t[rlbr_pkg::TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == rlbr_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r   <= dividend;
      rem_r  <= '0;
      step_r <= rlbr_pkg::STEP_W'(rlbr_pkg::MOD_STEPS);
    end else if (busy_r) begin
      sh_r   <= sh_r << rlbr_pkg::MOD_BITS;
      rem_r  <= rem_nxt;
      step_r <= step_r - rlbr_pkg::STEP_W'(1);
    end
  end

  assign done = done_r;
  assign rem  = rlbr_pkg::IDX_W'(rem_r);

endmodule
`default_nettype wire

@@ hdl/ring_log_block_reclaimer.sv @@
// Top level of the ring log block reclaimer: control sequencer, bounds and result register.
`default_nettype none
// Reader counters live in a single-port-write memory walked one counter per cycle;
// each input word produces exactly one result word. Reserve, rejected appends and
// zero-length appends and locks pass from accept through S_DONE, which loads the
// result register, and the next word is accepted once back in S_IDLE. Nonzero lock and
// unlock first reduce the range start modulo the block count in the remainder unit,
// then walk the range at one counter per cycle; append walks from the upper bound
// without the remainder step. A counter limit fault rolls back the counters already
// touched, one per cycle. A successful unlock, zero-length included, then walks the
// lower bound forward at one block per cycle. A bound that wraps past 2^48 costs one
// more remainder pass. A result held by out_stall holds off the next word. After reset
// and after every ring_blocks write the block clears all 1024 counters, one per
// cycle, and holds off input words until the clear finishes.
module ring_log_block_reclaimer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rlbr_pkg::TOT_W-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_op,
  input  wire logic [rlbr_pkg::BOUND_W-1:0]   in_range_start,
  input  wire logic [rlbr_pkg::TOT_W-1:0]     in_block_total,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_status,
  output logic [rlbr_pkg::BOUND_W-1:0]        out_appended_start,
  output logic [rlbr_pkg::BOUND_W-1:0]        out_lower_mark,
  output logic [rlbr_pkg::BOUND_W-1:0]        out_upper_mark,
  output logic [rlbr_pkg::TOT_W-1:0]          out_free_blocks,
  output logic [rlbr_pkg::TOT_W-1:0]          out_freed_now
);

  localparam int BW = rlbr_pkg::BOUND_W;
  localparam int TW = rlbr_pkg::TOT_W;
  localparam int IW = rlbr_pkg::IDX_W;
  localparam int CW = rlbr_pkg::CNT_W;

  rlbr_pkg::state_t   state_r, state_nxt;
  logic [TW-1:0]      n_r, n_nxt;
  logic [BW-1:0]      lower_r, lower_nxt;
  logic [BW-1:0]      upper_r, upper_nxt;
  logic [IW-1:0]      lower_idx_r, lower_idx_nxt;
  logic [IW-1:0]      upper_idx_r, upper_idx_nxt;
  logic [TW-1:0]      free_r, free_nxt;
  logic [TW-1:0]      reserved_r, reserved_nxt;
  logic [IW-1:0]      clr_idx_r, clr_idx_nxt;

  rlbr_pkg::op_t      op_r, op_nxt;
  logic [TW-1:0]      total_r, total_nxt;
  logic [IW-1:0]      base_idx_r, base_idx_nxt;
  logic [IW-1:0]      pos_r, pos_nxt;
  logic [IW-1:0]      iss_idx_r, iss_idx_nxt;
  logic [TW-1:0]      iss_cnt_r, iss_cnt_nxt;
  logic [TW-1:0]      done_cnt_r, done_cnt_nxt;
  logic [TW-1:0]      lim_r, lim_nxt;
  logic               undo_r, undo_nxt;
  logic               cur_v_r, cur_v_nxt;
  logic               fwd_v_r, fwd_v_nxt;
  logic [IW-1:0]      fwd_idx_r, fwd_idx_nxt;
  logic [CW-1:0]      fwd_data_r, fwd_data_nxt;
  logic               fix_lower_r, fix_lower_nxt;
  rlbr_pkg::status_t  status_r, status_nxt;
  logic [BW-1:0]      appended_r, appended_nxt;
  logic [TW-1:0]      freed_r, freed_nxt;

  logic               out_valid_r;
  logic               out_load;

  rlbr_pkg::mem_req_t mem_req;
  logic [CW-1:0]      mem_rdata;

  logic               mod_start;
  logic [BW-1:0]      mod_dvd;
  logic               mod_done;
  logic [IW-1:0]      mod_rem;

  logic               in_acc;
  rlbr_pkg::op_t      in_op_e;
  logic [TW-1:0]      n_cfg;

  logic [CW-1:0]      rd_val;
  logic               dir_up;
  logic               cnt_fault;
  logic [CW-1:0]      cnt_new;
  logic [IW-1:0]      pos_inc;
  logic [IW-1:0]      iss_inc;
  logic [TW-1:0]      done_inc;
  logic [BW:0]        up_sum;
  logic [BW-1:0]      live;
  logic               rc_take;
  logic               rc_stop;
  logic [TW-1:0]      rc_cnt;
  logic [IW-1:0]      rc_pos;
  logic [BW:0]        lo_sum;

  rlbr_count_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  rlbr_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (n_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign in_stall = (state_r != rlbr_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_op_e  = rlbr_pkg::op_t'(in_op);
  assign n_cfg    = rlbr_pkg::eff_blocks(cfg_wdata);

  assign rd_val    = (fwd_v_r && fwd_idx_r == pos_r) ? fwd_data_r : mem_rdata;
  assign dir_up    = (op_r != rlbr_pkg::OP_UNLOCK) ^ undo_r;
  assign cnt_fault = !undo_r && (dir_up ? (&rd_val) : (rd_val == '0));
  assign cnt_new   = dir_up ? rd_val + CW'(1) : rd_val - CW'(1);
  assign pos_inc   = rlbr_pkg::idx_inc(pos_r, n_r);
  assign iss_inc   = rlbr_pkg::idx_inc(iss_idx_r, n_r);
  assign done_inc  = done_cnt_r + TW'(1);
  assign up_sum    = {1'b0, upper_r} + (BW+1)'(total_r);
  assign live      = upper_r - lower_r;

  assign rc_take = cur_v_r && (mem_rdata == '0);
  assign rc_cnt  = rc_take ? done_inc : done_cnt_r;
  assign rc_pos  = rc_take ? pos_inc : pos_r;
  assign rc_stop = cur_v_r ? (!rc_take || done_inc == lim_r) : (iss_cnt_r == lim_r);
  assign lo_sum  = {1'b0, lower_r} + (BW+1)'(rc_cnt);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    lower_nxt     = lower_r;
    upper_nxt     = upper_r;
    lower_idx_nxt = lower_idx_r;
    upper_idx_nxt = upper_idx_r;
    free_nxt      = free_r;
    reserved_nxt  = reserved_r;
    clr_idx_nxt   = clr_idx_r;
    op_nxt        = op_r;
    total_nxt     = total_r;
    base_idx_nxt  = base_idx_r;
    pos_nxt       = pos_r;
    iss_idx_nxt   = iss_idx_r;
    iss_cnt_nxt   = iss_cnt_r;
    done_cnt_nxt  = done_cnt_r;
    lim_nxt       = lim_r;
    undo_nxt      = undo_r;
    cur_v_nxt     = 1'b0;
    fwd_v_nxt     = 1'b0;
    fwd_idx_nxt   = fwd_idx_r;
    fwd_data_nxt  = fwd_data_r;
    fix_lower_nxt = fix_lower_r;
    status_nxt    = status_r;
    appended_nxt  = appended_r;
    freed_nxt     = freed_r;
    out_load      = 1'b0;
    mod_start     = 1'b0;
    mod_dvd       = in_range_start;
    mem_req.we    = 1'b0;
    mem_req.waddr = pos_r;
    mem_req.wdata = cnt_new;
    mem_req.raddr = iss_idx_r;

    unique case (state_r)
      rlbr_pkg::S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_idx_r;
        mem_req.wdata = '0;
        clr_idx_nxt   = clr_idx_r + IW'(1);
        if (32'(clr_idx_r) == rlbr_pkg::MAX_BLOCKS - 1) begin
          state_nxt = rlbr_pkg::S_IDLE;
        end
      end

      rlbr_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_op_e;
          total_nxt    = in_block_total;
          status_nxt   = rlbr_pkg::ST_OK;
          appended_nxt = '0;
          freed_nxt    = '0;
          undo_nxt     = 1'b0;
          done_cnt_nxt = '0;
          iss_cnt_nxt  = '0;
          lim_nxt      = in_block_total;
          state_nxt    = rlbr_pkg::S_DONE;
          unique case (in_op_e)
            rlbr_pkg::OP_RESERVE: begin
              if (in_block_total > free_r) begin
                status_nxt = rlbr_pkg::ST_NO_FREE;
              end else begin
                free_nxt     = free_r - in_block_total;
                reserved_nxt = reserved_r + in_block_total;
              end
            end
            rlbr_pkg::OP_APPEND: begin
              if (in_block_total > reserved_r) begin
                status_nxt = rlbr_pkg::ST_NO_RSV;
              end else if (in_block_total == '0) begin
                appended_nxt = upper_r;
              end else begin
                base_idx_nxt = upper_idx_r;
                pos_nxt      = upper_idx_r;
                iss_idx_nxt  = upper_idx_r;
                state_nxt    = rlbr_pkg::S_WALK;
              end
            end
            rlbr_pkg::OP_LOCK, rlbr_pkg::OP_UNLOCK: begin
              if (in_block_total == '0) begin
                if (in_op_e == rlbr_pkg::OP_UNLOCK) begin
                  state_nxt = rlbr_pkg::S_RSETUP;
                end
              end else begin
                mod_start = 1'b1;
                state_nxt = rlbr_pkg::S_MOD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      rlbr_pkg::S_MOD: begin
        if (mod_done) begin
          base_idx_nxt = mod_rem;
          pos_nxt      = mod_rem;
          iss_idx_nxt  = mod_rem;
          state_nxt    = rlbr_pkg::S_WALK;
        end
      end

      rlbr_pkg::S_WALK: begin
        if (cur_v_r && cnt_fault) begin
          // roll back the counters already moved
          lim_nxt      = done_cnt_r;
          undo_nxt     = 1'b1;
          done_cnt_nxt = '0;
          iss_cnt_nxt  = '0;
          pos_nxt      = base_idx_r;
          iss_idx_nxt  = base_idx_r;
          if (done_cnt_r == '0) begin
            status_nxt = rlbr_pkg::ST_LIMIT;
            state_nxt  = rlbr_pkg::S_DONE;
          end
        end else begin
          if (cur_v_r) begin
            mem_req.we   = 1'b1;
            fwd_v_nxt    = 1'b1;
            fwd_idx_nxt  = pos_r;
            fwd_data_nxt = cnt_new;
            pos_nxt      = pos_inc;
            done_cnt_nxt = done_inc;
          end
          if (cur_v_r && done_inc == lim_r) begin
            if (undo_r) begin
              status_nxt = rlbr_pkg::ST_LIMIT;
              state_nxt  = rlbr_pkg::S_DONE;
            end else if (op_r == rlbr_pkg::OP_APPEND) begin
              appended_nxt  = upper_r;
              upper_nxt     = up_sum[BW-1:0];
              upper_idx_nxt = pos_inc;
              reserved_nxt  = reserved_r - total_r;
              if (up_sum[BW]) begin
                fix_lower_nxt = 1'b0;
                mod_start     = 1'b1;
                mod_dvd       = up_sum[BW-1:0];
                state_nxt     = rlbr_pkg::S_FIX;
              end else begin
                state_nxt = rlbr_pkg::S_DONE;
              end
            end else if (op_r == rlbr_pkg::OP_UNLOCK) begin
              state_nxt = rlbr_pkg::S_RSETUP;
            end else begin
              state_nxt = rlbr_pkg::S_DONE;
            end
          end else if (iss_cnt_r < lim_r) begin
            cur_v_nxt   = 1'b1;
            iss_idx_nxt = iss_inc;
            iss_cnt_nxt = iss_cnt_r + TW'(1);
          end
        end
      end

      rlbr_pkg::S_RSETUP: begin
        lim_nxt = (live >= BW'(n_r)) ? n_r : live[TW-1:0];
        done_cnt_nxt = '0;
        iss_cnt_nxt  = '0;
        pos_nxt      = lower_idx_r;
        iss_idx_nxt  = lower_idx_r;
        state_nxt    = rlbr_pkg::S_RECL;
      end

      rlbr_pkg::S_RECL: begin
        if (rc_stop) begin
          freed_nxt     = rc_cnt;
          free_nxt      = free_r + rc_cnt;
          lower_nxt     = lo_sum[BW-1:0];
          lower_idx_nxt = rc_pos;
          if (lo_sum[BW]) begin
            fix_lower_nxt = 1'b1;
            mod_start     = 1'b1;
            mod_dvd       = lo_sum[BW-1:0];
            state_nxt     = rlbr_pkg::S_FIX;
          end else begin
            state_nxt = rlbr_pkg::S_DONE;
          end
        end else begin
          done_cnt_nxt = rc_cnt;
          pos_nxt      = rc_pos;
          if (iss_cnt_r < lim_r) begin
            cur_v_nxt   = 1'b1;
            iss_idx_nxt = iss_inc;
            iss_cnt_nxt = iss_cnt_r + TW'(1);
          end
        end
      end

      rlbr_pkg::S_FIX: begin
        if (mod_done) begin
          if (fix_lower_r) begin
            lower_idx_nxt = mod_rem;
          end else begin
            upper_idx_nxt = mod_rem;
          end
          state_nxt = rlbr_pkg::S_DONE;
        end
      end

      rlbr_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = rlbr_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rlbr_pkg::S_CLEAR;
      end
    endcase

    if (cfg_we) begin
      n_nxt         = n_cfg;
      free_nxt      = n_cfg;
      reserved_nxt  = '0;
      lower_nxt     = '0;
      upper_nxt     = '0;
      lower_idx_nxt = '0;
      upper_idx_nxt = '0;
      clr_idx_nxt   = '0;
      state_nxt     = rlbr_pkg::S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlbr_pkg::S_CLEAR;
      n_r         <= rlbr_pkg::eff_blocks(rlbr_pkg::RESET_RING);
      free_r      <= rlbr_pkg::eff_blocks(rlbr_pkg::RESET_RING);
      reserved_r  <= '0;
      lower_r     <= '0;
      upper_r     <= '0;
      lower_idx_r <= '0;
      upper_idx_r <= '0;
      clr_idx_r   <= '0;
      undo_r      <= 1'b0;
      cur_v_r     <= 1'b0;
      fwd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      free_r      <= free_nxt;
      reserved_r  <= reserved_nxt;
      lower_r     <= lower_nxt;
      upper_r     <= upper_nxt;
      lower_idx_r <= lower_idx_nxt;
      upper_idx_r <= upper_idx_nxt;
      clr_idx_r   <= clr_idx_nxt;
      undo_r      <= undo_nxt;
      cur_v_r     <= cur_v_nxt;
      fwd_v_r     <= fwd_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    total_r     <= total_nxt;
    base_idx_r  <= base_idx_nxt;
    pos_r       <= pos_nxt;
    iss_idx_r   <= iss_idx_nxt;
    iss_cnt_r   <= iss_cnt_nxt;
    done_cnt_r  <= done_cnt_nxt;
    lim_r       <= lim_nxt;
    fwd_idx_r   <= fwd_idx_nxt;
    fwd_data_r  <= fwd_data_nxt;
    fix_lower_r <= fix_lower_nxt;
    status_r    <= status_nxt;
    appended_r  <= appended_nxt;
    freed_r     <= freed_nxt;
    if (out_load) begin
      out_status         <= status_r;
      out_appended_start <= appended_r;
      out_lower_mark     <= lower_r;
      out_upper_mark     <= upper_r;
      out_free_blocks    <= free_r;
      out_freed_now      <= freed_r;
    end
  end

  assign out_valid = out_valid_r;

  logic [BW:0] acct;
  assign acct = (BW+1)'(free_r) + (BW+1)'(reserved_r) + (BW+1)'(live);

  a_block_conservation: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlbr_pkg::S_IDLE) |-> (acct == (BW+1)'(n_r)))
    else $error("free, reserved and live blocks do not add up to the block count");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlbr_pkg::S_IDLE) |->
      (32'(lower_idx_r) < 32'(n_r)) && (32'(upper_idx_r) < 32'(n_r)))
    else $error("bound index beyond block count");

  a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == rlbr_pkg::S_CLEAR) || (state_r == rlbr_pkg::S_WALK))
    else $error("counter write outside clear or range walk");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rlbr_pkg::S_DONE))
    else $error("result word raised without a finished item");

endmodule
`default_nettype wire
